// File: sv/abp_pkg.sv
// shared constants and types for the adaptive backoff pacer
`default_nettype none

package abp_pkg;

	// fixed-point format of all time values
	localparam int unsigned FRAC_BITS = 8;
	localparam int unsigned TIME_W    = 24;
	localparam int unsigned PACE_W    = TIME_W + 1;
	localparam int unsigned STREAK_W  = 16;
	localparam int unsigned CFG_IDX_W = 3;

	// blend and shrink weights over 256
	localparam int unsigned COEF_SHIFT = 8;
	localparam int unsigned KEEP_W     = 179;
	localparam int unsigned GAIN_W     = 77;
	localparam int unsigned SHRINK_W   = 243;

	// streak thresholds
	localparam logic [STREAK_W-1:0] SHRINK_STREAK = STREAK_W'(20);
	localparam logic [STREAK_W-1:0] COOL_STREAK   = STREAK_W'(10);
	localparam logic [STREAK_W-1:0] STREAK_MAX    = {STREAK_W{1'b1}};

	// 2 ms shrink floor and 200 ms short cool-down
	localparam logic [TIME_W-1:0] SHRINK_FLOOR = TIME_W'(2 << FRAC_BITS);
	localparam logic [TIME_W-1:0] SHORT_COOL   = TIME_W'(200 << FRAC_BITS);

	// register reset values
	localparam logic [TIME_W-1:0]   RST_INITIAL_DELAY    = TIME_W'(25600);
	localparam logic [TIME_W-1:0]   RST_MIN_DELAY        = TIME_W'(256);
	localparam logic [TIME_W-1:0]   RST_MAX_DELAY        = TIME_W'(1280000);
	localparam logic [STREAK_W-1:0] RST_STREAK_LIMIT     = STREAK_W'(100);
	localparam logic [TIME_W-1:0]   RST_INITIAL_COOLDOWN = TIME_W'(128000);

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INITIAL_DELAY    = 3'd0,
		CFG_MIN_DELAY        = 3'd1,
		CFG_MAX_DELAY        = 3'd2,
		CFG_STREAK_LIMIT     = 3'd3,
		CFG_INITIAL_COOLDOWN = 3'd4
	} cfg_idx_t;

	// operation codes
	localparam logic OP_REPORT  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

endpackage

`default_nettype wire

// File: sv/adaptive_backoff_pacer.sv
// adaptive backoff pacer: learned delay update with restart, backoff, blend, shrink and clamp
// datapath: an input beat passes the input register, then the result register
// throughput: one beat per cycle while the result stream is not stalled; the state update is a combinational
// constant shift-add path from the input register into the state and result registers
// reset: config registers return to defaults, state restarts, both stages empty
// a stalled result holds the input stage; no beat is dropped
`default_nettype none

module adaptive_backoff_pacer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // [23:0] response_time
	input  wire logic [1:0]  s_axis_tuser,  // [0] op, [1] backoff_event
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata   // [24:0] pacing_delay, [48:25] base_delay,
	                                        // [49] cooldown_active, [55:50] zero
);

	localparam int unsigned TW = abp_pkg::TIME_W;
	localparam int unsigned PW = abp_pkg::PACE_W;
	localparam int unsigned SW = abp_pkg::STREAK_W;
	localparam int unsigned MW = TW + abp_pkg::COEF_SHIFT + 1;

	// configuration registers
	logic [TW-1:0] initial_delay_q, min_delay_q, max_delay_q, initial_cooldown_q;
	logic [SW-1:0] streak_limit_q;

	// pacer state
	logic [TW-1:0] learned_q, cooldown_q;
	logic [SW-1:0] streak_q;

	// input stage
	logic          valid_s1;
	logic          op_s1, backoff_s1;
	logic [TW-1:0] rt_s1;

	// result stage
	logic          valid_s2;
	logic [PW-1:0] pace_s2;
	logic [TW-1:0] base_s2;
	logic          active_s2;

	logic advance;

	// next-state values
	logic [TW-1:0] learned_d, cooldown_d;
	logic [SW-1:0] streak_d;
	logic          active_d;
	logic [PW-1:0] pace_d;

	// update datapath
	logic [TW:0]   doubled;
	logic [TW:0]   sug;
	logic          blend_en;
	logic [MW-1:0] blend_sum;
	logic [TW-1:0] d_blend;
	logic [MW-1:0] shrink_prod;
	logic [TW-1:0] d_shrink;
	logic [TW-1:0] d_min;
	logic [SW-1:0] streak_inc;

	// handshake: input stage moves when the result stage is free or draining
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_delay_q    <= abp_pkg::RST_INITIAL_DELAY;
			min_delay_q        <= abp_pkg::RST_MIN_DELAY;
			max_delay_q        <= abp_pkg::RST_MAX_DELAY;
			streak_limit_q     <= abp_pkg::RST_STREAK_LIMIT;
			initial_cooldown_q <= abp_pkg::RST_INITIAL_COOLDOWN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				abp_pkg::CFG_INITIAL_DELAY:    initial_delay_q    <= cfg_data;
				abp_pkg::CFG_MIN_DELAY:        min_delay_q        <= cfg_data;
				abp_pkg::CFG_MAX_DELAY:        max_delay_q        <= cfg_data;
				abp_pkg::CFG_STREAK_LIMIT:     streak_limit_q     <= cfg_data[SW-1:0];
				abp_pkg::CFG_INITIAL_COOLDOWN: initial_cooldown_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1      <= s_axis_tuser[0];
			backoff_s1 <= s_axis_tuser[1];
			rt_s1      <= s_axis_tdata;
		end
	end

	// success path: blend toward 1.5x response time, shrink on long streak, clamp
	always_comb begin
		sug        = {1'b0, rt_s1} + {2'b00, rt_s1[TW-1:1]};
		blend_en   = (sug != '0) && (sug < {1'b0, max_delay_q});
		blend_sum  = MW'(learned_q) * MW'(abp_pkg::KEEP_W)
		           + MW'(sug) * MW'(abp_pkg::GAIN_W);
		d_blend    = blend_en ? blend_sum[abp_pkg::COEF_SHIFT +: TW] : learned_q;
		streak_inc = (streak_q != abp_pkg::STREAK_MAX) ? streak_q + SW'(1) : streak_q;
		shrink_prod = MW'(d_blend) * MW'(abp_pkg::SHRINK_W);
		if (streak_inc > abp_pkg::SHRINK_STREAK && d_blend > abp_pkg::SHRINK_FLOOR) begin
			d_shrink = shrink_prod[abp_pkg::COEF_SHIFT +: TW];
		end else begin
			d_shrink = d_blend;
		end
		d_min   = (d_shrink < min_delay_q) ? min_delay_q : d_shrink;
		doubled = {learned_q, 1'b0};
	end

	// next state by operation
	always_comb begin
		learned_d  = learned_q;
		streak_d   = streak_q;
		cooldown_d = cooldown_q;
		priority if (op_s1 == abp_pkg::OP_RESTART) begin
			learned_d  = initial_delay_q;
			streak_d   = '0;
			cooldown_d = initial_cooldown_q;
		end else if (backoff_s1) begin
			learned_d  = (doubled > {1'b0, max_delay_q}) ? max_delay_q : doubled[TW-1:0];
			streak_d   = '0;
			cooldown_d = learned_d;
		end else begin
			streak_d  = streak_inc;
			learned_d = (d_min > max_delay_q) ? max_delay_q : d_min;
			if (streak_inc > abp_pkg::COOL_STREAK) begin
				cooldown_d = abp_pkg::SHORT_COOL;
			end
		end
		active_d = streak_d >= streak_limit_q;
		pace_d   = {1'b0, learned_d} + (active_d ? {1'b0, cooldown_d} : '0);
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learned_q  <= abp_pkg::RST_INITIAL_DELAY;
			streak_q   <= '0;
			cooldown_q <= abp_pkg::RST_INITIAL_COOLDOWN;
		end else if (advance) begin
			learned_q  <= learned_d;
			streak_q   <= streak_d;
			cooldown_q <= cooldown_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pace_s2   <= pace_d;
			base_s2   <= learned_d;
			active_s2 <= active_d;
		end
	end

	// result beat
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'b0, active_s2, base_s2, pace_s2};

endmodule

`default_nettype wire
